// ===== rtl/bms_pkg.sv =====
// Package for the bar meter: constants, register indexes and the divider interface types.
`timescale 1ns / 1ps

package bms_pkg;

    // Default values of the module parameters.
    localparam int MAX_COLUMNS_DEF  = 32;
    localparam int MAX_SEGMENTS_DEF = 16;

    // At most this many results come from one item.
    localparam int RESULT_CAP = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CEILING   = 2'd0;
    localparam logic [1:0] CFG_SEGMENTS  = 2'd1;
    localparam logic [1:0] CFG_DECAY     = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    // Register values after reset.
    localparam logic [15:0] CEILING_RST   = 16'd614;
    localparam logic [4:0]  SEGMENTS_RST  = 5'd8;
    localparam logic [7:0]  DECAY_RST     = 8'd128;
    localparam logic [15:0] THRESHOLD_RST = 16'd614;

    // A full segment, 1.0 in Q1.14.
    localparam logic [14:0] FILL_ONE = 15'd16384;

    // Step counts of the two divisions.
    localparam logic [4:0] WIDTH_STEPS = 5'd16;
    localparam logic [4:0] FILL_STEPS  = 5'd14;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [15:0] rem_init;
        logic [15:0] dividend;
        logic [4:0]  steps;
        logic [15:0] divisor;
    } div_req_t;

    // Answer from the shared divider.
    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/bms_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bms_divider
    import bms_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvd_reg, dvd_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [15:0] quot_reg, quot_next;
    logic [16:0] shifted;
    logic [16:0] trial;
    logic        q_bit;

    // The remainder always stays below the divisor, so 16 bits carry it.
    always_comb begin
        shifted = {rem_reg, dvd_reg[15]};
        trial   = shifted - {1'b0, dvs_reg};
        q_bit   = (shifted >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = q_bit ? trial[15:0] : shifted[15:0];
            dvd_next  = {dvd_reg[14:0], 1'b0};
            quot_next = {quot_reg[14:0], q_bit};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ===== rtl/bms_held_store.sv =====
// Held brightness memory, one write and one registered read port.
`timescale 1ns / 1ps

module bms_held_store
    import bms_pkg::*;
#(
    parameter int AW = 9
)(
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [2**AW];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bar_meter_segment_decay.sv =====
// Top level of the bar meter: sequencer, configuration registers and result register.
`timescale 1ns / 1ps

// Bar-graph meter with a decaying hold. Each item carries a column number and
// that column's band level; the block returns one item per shown segment,
// bottom segment first, with last set on the topmost one. A column at or
// above MAX_COLUMNS gives no results. All divisions run on one shared
// restoring divider that produces one quotient bit per cycle, so the rate is
// set by that divider. Once an item is taken, the segment width is found by
// a division of 16 quotient bits. After that, each segment is read from the
// held store and classed as full, empty or partly filled; a partly filled one
// also runs a fill division of 14 quotient bits. Each result waits in S_SUM
// until the result register is free. At most one segment of a column can be
// partly filled. A new item is taken only after the last segment of the
// current one has been written back to the held store.
// After reset the held store is swept to zero, one entry a cycle, over all
// 2**(column bits + segment bits) entries (512 with the default parameters);
// no item is accepted during the sweep, though configuration writes are.
// The user must write configuration only while the block is idle; the block
// itself does not enforce this. A result that waits on m_ready does not stop
// the next segment's division, nor the next item being taken once the
// current one has finished.

module bar_meter_segment_decay
    import bms_pkg::*;
#(
    parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_column,
    input  logic [15:0] s_level,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_out_column,
    output logic [3:0]  m_segment,
    output logic [15:0] m_brightness,
    output logic        m_seg_active,
    output logic        m_last
);

    // Largest number of segments actually shown.
    localparam int NCAP = (MAX_SEGMENTS < RESULT_CAP) ? MAX_SEGMENTS : RESULT_CAP;
    // Column and segment address bits of the held store. Only columns that
    // fit the five-bit port and only segments below the cap are ever used.
    localparam int CBITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CAW   = (CBITS > 5) ? 5 : CBITS;
    localparam int SBITS = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SAW   = (SBITS > 4) ? 4 : SBITS;
    localparam int AW    = CAW + SAW;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_WDIV  = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_CLASS = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_WB    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] ceiling_reg;
    logic [4:0]  segments_reg;
    logic [7:0]  decay_reg;
    logic [15:0] threshold_reg;

    // Working registers of the current item.
    logic [4:0]         col_reg, col_next;
    logic [15:0]        level_reg, level_next;
    logic [4:0]         n_reg, n_next;
    logic [3:0]         seg_reg, seg_next;
    logic [15:0]        w_reg, w_next;
    logic [16:0]        thr_reg, thr_next;
    logic signed [17:0] diff_reg, diff_next;
    logic [14:0]        fill_reg, fill_next;
    logic [AW-1:0]      clr_reg, clr_next;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic [4:0]  m_col_reg, m_col_next;
    logic [3:0]  m_seg_reg, m_seg_next;
    logic [15:0] m_bright_reg, m_bright_next;
    logic        m_seg_active_reg, m_seg_active_next;
    logic        m_last_reg, m_last_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [15:0]   st_wdata;
    logic [AW-1:0] st_raddr;
    logic [15:0]   st_rdata;

    logic        accept;
    logic        col_ok;
    logic [4:0]  n_eff;
    logic [16:0] sum;
    logic [15:0] sum_sat;
    logic [23:0] decayed;
    logic        out_free;

    // Segment count: zero counts as one, and the count is capped.
    always_comb begin
        if (segments_reg == 5'd0) begin
            n_eff = 5'd1;
        end else if (32'(segments_reg) > NCAP) begin
            n_eff = 5'(NCAP);
        end else begin
            n_eff = segments_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign col_ok  = (32'(s_column) < MAX_COLUMNS);

    // Brightness is the fill plus the held value, saturated to 16 bits.
    assign sum     = {2'b00, fill_reg} + {1'b0, st_rdata};
    assign sum_sat = sum[16] ? 16'hFFFF : sum[15:0];
    assign decayed = {8'd0, m_bright_reg} * {16'd0, decay_reg};

    // The result register can take a new result when it is empty or being read.
    assign out_free = !m_valid_reg || m_ready;

    assign st_raddr = {col_reg[CAW-1:0], seg_reg[SAW-1:0]};
    assign st_we    = (state_reg == S_CLEAR) || (state_reg == S_WB);
    assign st_waddr = (state_reg == S_CLEAR) ? clr_reg : st_raddr;
    assign st_wdata = (state_reg == S_CLEAR) ? 16'd0 : decayed[23:8];

    always_comb begin
        state_next        = state_reg;
        col_next          = col_reg;
        level_next        = level_reg;
        n_next            = n_reg;
        seg_next          = seg_reg;
        w_next            = w_reg;
        thr_next          = thr_reg;
        diff_next         = diff_reg;
        fill_next         = fill_reg;
        clr_next          = clr_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_col_next        = m_col_reg;
        m_seg_next        = m_seg_reg;
        m_bright_next     = m_bright_reg;
        m_seg_active_next = m_seg_active_reg;
        m_last_next       = m_last_reg;

        div_req          = '0;
        div_req.divisor  = w_reg;

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && col_ok) begin
                    col_next         = s_column;
                    level_next       = s_level;
                    n_next           = n_eff;
                    seg_next         = '0;
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.dividend = ceiling_reg;
                    div_req.steps    = WIDTH_STEPS;
                    div_req.divisor  = {11'd0, n_eff};
                    state_next       = S_WDIV;
                end
            end
            S_WDIV: begin
                if (div_rsp.done) begin
                    w_next     = div_rsp.quotient;
                    thr_next   = {1'b0, div_rsp.quotient};
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // The store read is under way; work out level minus the
                // segment's upper bound meanwhile.
                diff_next  = $signed({2'b00, level_reg}) - $signed({1'b0, thr_reg});
                state_next = S_CLASS;
            end
            S_CLASS: begin
                if (w_reg == 16'd0 || diff_reg >= $signed({2'b00, w_reg})) begin
                    fill_next  = FILL_ONE;
                    state_next = S_SUM;
                end else if (diff_reg[17]) begin
                    fill_next  = '0;
                    state_next = S_SUM;
                end else begin
                    // Partial fill: the remainder starts at the difference and
                    // fourteen zero bits are brought down.
                    div_req.start    = 1'b1;
                    div_req.rem_init = diff_reg[15:0];
                    div_req.dividend = '0;
                    div_req.steps    = FILL_STEPS;
                    state_next       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    fill_next  = {1'b0, div_rsp.quotient[13:0]};
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_col_next        = col_reg;
                    m_seg_next        = seg_reg;
                    m_bright_next     = sum_sat;
                    m_seg_active_next = (sum_sat > threshold_reg);
                    m_last_next       = ({1'b0, seg_reg} + 5'd1 == n_reg);
                    state_next        = S_WB;
                end
            end
            S_WB: begin
                // The decayed brightness goes back to the store this cycle.
                thr_next = thr_reg + {1'b0, w_reg};
                seg_next = seg_reg + 4'd1;
                if ({1'b0, seg_reg} + 5'd1 == n_reg) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        col_reg          <= col_next;
        level_reg        <= level_next;
        n_reg            <= n_next;
        seg_reg          <= seg_next;
        w_reg            <= w_next;
        thr_reg          <= thr_next;
        diff_reg         <= diff_next;
        fill_reg         <= fill_next;
        m_col_reg        <= m_col_next;
        m_seg_reg        <= m_seg_next;
        m_bright_reg     <= m_bright_next;
        m_seg_active_reg <= m_seg_active_next;
        m_last_reg       <= m_last_next;
    end

    // Configuration registers; every index of the port names a register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg   <= CEILING_RST;
            segments_reg  <= SEGMENTS_RST;
            decay_reg     <= DECAY_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CEILING:   ceiling_reg   <= cfg_wdata;
                CFG_SEGMENTS:  segments_reg  <= cfg_wdata[4:0];
                CFG_DECAY:     decay_reg     <= cfg_wdata[7:0];
                CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bms_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    bms_held_store #(
        .AW (AW)
    ) u_held_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_out_column = m_col_reg;
    assign m_segment    = m_seg_reg;
    assign m_brightness = m_bright_reg;
    assign m_seg_active = m_seg_active_reg;
    assign m_last       = m_last_reg;

endmodule

// ===== tb/sv/segment_brightness_checker.sv =====
// Checker for the bar meter: predicts the brightness of every segment and compares each result item.
`timescale 1ns / 1ps

module segment_brightness_checker
    import bms_pkg::*;
#(
    parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [4:0]  s_column,
    input  logic [15:0] s_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [4:0]  m_out_column,
    input  logic [3:0]  m_segment,
    input  logic [15:0] m_brightness,
    input  logic        m_seg_active,
    input  logic        m_last,
    output int          failures,
    output int          outstanding
);

    typedef struct packed {
        logic [4:0]  column;
        logic [3:0]  segment;
        logic [15:0] brightness;
        logic        active;
        logic        last;
    } segment_result_t;

    // Local copy of the registers and of the decaying hold store.
    logic [15:0] ceiling_q;
    logic [4:0]  segments_q;
    logic [7:0]  decay_q;
    logic [15:0] threshold_q;
    logic [15:0] held [MAX_COLUMNS][MAX_SEGMENTS];

    segment_result_t expected_segments[$];
    segment_result_t oldest;
    int              fail_count = 0;
    int              queued = 0;

    assign failures    = fail_count;
    assign outstanding = queued;

    task automatic predict_column_segments(input logic [4:0] col, input logic [15:0] level);
        int unsigned     n;
        int unsigned     w;
        int unsigned     fill;
        int unsigned     sum;
        longint          v;
        longint          wl;
        segment_result_t r;
        if (int'(col) >= MAX_COLUMNS) begin
            return;
        end
        n = segments_q;
        if (n == 0) n = 1;
        if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
        if (n > RESULT_CAP) n = RESULT_CAP;
        w  = ceiling_q / n;
        wl = w;
        for (int i = 0; i < int'(n); i++) begin
            if (w == 0) begin
                fill = 16384;
            end else begin
                v = longint'(level) - longint'(i + 1) * wl;
                if (v >= wl) fill = 16384;
                else if (v < 0) fill = 0;
                else fill = 32'((v <<< 14) / wl);
            end
            sum = fill + held[col][i];
            if (sum > 65535) sum = 65535;
            held[col][i] = 16'((sum * decay_q) >> 8);
            r.column     = col;
            r.segment    = 4'(i);
            r.brightness = sum[15:0];
            r.active     = (sum > threshold_q);
            r.last       = (i + 1 == int'(n));
            expected_segments = {expected_segments, r};
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_q   = CEILING_RST;
            segments_q  = SEGMENTS_RST;
            decay_q     = DECAY_RST;
            threshold_q = THRESHOLD_RST;
            for (int c = 0; c < MAX_COLUMNS; c++)
                for (int s = 0; s < MAX_SEGMENTS; s++)
                    held[c][s] = '0;
            expected_segments.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CEILING:   ceiling_q   = cfg_wdata;
                    CFG_SEGMENTS:  segments_q  = cfg_wdata[4:0];
                    CFG_DECAY:     decay_q     = cfg_wdata[7:0];
                    CFG_THRESHOLD: threshold_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_segments.size() == 0) begin
                    $error("Unexpected result item: column %0d segment %0d brightness %0d",
                           m_out_column, m_segment, m_brightness);
                    fail_count++;
                end else begin
                    oldest = expected_segments.pop_front();
                    check_field("out_column", 16'(oldest.column), 16'(m_out_column));
                    check_field("segment", 16'(oldest.segment), 16'(m_segment));
                    check_field("brightness", oldest.brightness, m_brightness);
                    check_field("active", 16'(oldest.active), 16'(m_seg_active));
                    check_field("last", 16'(oldest.last), 16'(m_last));
                end
            end
            if (s_valid && s_ready)
                predict_column_segments(s_column, s_level);
        end
        queued = expected_segments.size();
    end

endmodule

// ===== tb/sv/bar_meter_segment_decay_tb.sv =====
// Testbench top for the bar meter: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module bar_meter_segment_decay_tb;
    import bms_pkg::*;

    // The random part is split into phases, each with its own register settings.
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int IDLE_PERCENT    = 15;
    // Length of the deliberate receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES     = 400;
    // Cycles without any item moving on either channel before the run is
    // abandoned. The slowest legitimate quiet spell is the clearing sweep after
    // reset, or the hold-off plus one sixteen-segment column.
    localparam int QUIET_LIMIT     = 5000;
    // Settling time after the last result item has arrived.
    localparam int TAIL_CYCLES     = 40;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_CEILING;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [4:0]  s_column  = '0;
    logic [15:0] s_level   = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [4:0]  m_out_column;
    logic [3:0]  m_segment;
    logic [15:0] m_brightness;
    logic        m_seg_active;
    logic        m_last;

    // When steady is set neither side idles; hold_off keeps the receiver stalled.
    logic        steady   = 1'b0;
    logic        hold_off = 1'b0;
    // The ceiling most recently written, used to aim levels at partly filled segments.
    logic [15:0] cur_ceiling = CEILING_RST;

    int          failures;
    int          outstanding;

    bar_meter_segment_decay dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_column     (s_column),
        .s_level      (s_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_column (m_out_column),
        .m_segment    (m_segment),
        .m_brightness (m_brightness),
        .m_seg_active (m_seg_active),
        .m_last       (m_last)
    );

    segment_brightness_checker brightness_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_column     (s_column),
        .s_level      (s_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_column (m_out_column),
        .m_segment    (m_segment),
        .m_brightness (m_brightness),
        .m_seg_active (m_seg_active),
        .m_last       (m_last),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver decides afresh at every edge whether it takes the next result
    // item. One assignment per edge, so a ready that stays high is never toggled.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // All four registers are written on consecutive edges, so every phase sets
    // each one. Only called while the block has nothing in flight.
    task automatic write_config(input logic [15:0] ceil_v, input logic [4:0] segs_v,
                                input logic [7:0] decay_v, input logic [15:0] thr_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CEILING;
        cfg_wdata <= ceil_v;
        @(posedge aclk);
        cfg_index <= CFG_SEGMENTS;
        cfg_wdata <= {11'd0, segs_v};
        @(posedge aclk);
        cfg_index <= CFG_DECAY;
        cfg_wdata <= {8'd0, decay_v};
        @(posedge aclk);
        cfg_index <= CFG_THRESHOLD;
        cfg_wdata <= thr_v;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        cur_ceiling = ceil_v;
    endtask

    // Offers one item and returns at the edge where it is taken. Valid is left
    // high, so a following item goes out back to back unless an idle gap is drawn.
    task automatic send_level(input logic [4:0] col, input logic [15:0] level);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_column <= col;
        s_level  <= level;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Withdraws valid and waits until every predicted result item has come back.
    task automatic end_phase();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic random_config();
        logic [15:0] c;
        logic [15:0] t;
        logic [7:0]  d;
        case ($urandom_range(5))
            0:       c = 16'd0;
            1:       c = 16'hFFFF;
            2:       c = 16'($urandom_range(64, 1));
            3:       c = 16'($urandom_range(65535));
            default: c = 16'($urandom_range(4000, 200));
        endcase
        case ($urandom_range(3))
            0:       d = 8'd0;
            1:       d = 8'hFF;
            default: d = 8'($urandom_range(255));
        endcase
        case ($urandom_range(3))
            0:       t = 16'd0;
            1:       t = 16'hFFFF;
            2:       t = 16'($urandom_range(32768));
            default: t = 16'($urandom_range(65535));
        endcase
        write_config(c, 5'($urandom_range(31)), d, t);
    endtask

    // Half of the items go to four columns so that held values build up and
    // decay; half of the levels are aimed up to just above the ceiling, where
    // segments are partly filled, with the extremes and the full range mixed in.
    task automatic random_items(input int count);
        int unsigned bound;
        logic [4:0]  col;
        logic [15:0] level;
        repeat (count) begin
            bound = cur_ceiling + cur_ceiling / 8 + 1;
            if (bound > 65535) bound = 65535;
            col = $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
            case ($urandom_range(7))
                0:       level = 16'd0;
                1:       level = 16'hFFFF;
                2, 3:    level = 16'($urandom_range(65535));
                default: level = 16'($urandom_range(bound));
            endcase
            send_level(col, level);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Settings after reset: empty, full and partly filled columns, with the
        // top column repeated so that the held value adds to the fill.
        send_level(5'd0, 16'd0);
        send_level(5'd31, 16'hFFFF);
        send_level(5'd31, 16'hFFFF);
        send_level(5'd1, 16'd614);
        send_level(5'd2, 16'd191);
        send_level(5'd3, 16'd100);
        end_phase();

        // A ceiling of zero gives a zero segment width, so every segment is full.
        // With the slowest decay the hold climbs until the sum saturates.
        write_config(16'd0, 5'd16, 8'hFF, 16'd0);
        send_level(5'd5, 16'd0);
        send_level(5'd5, 16'hFFFF);
        send_level(5'd5, 16'd1234);
        send_level(5'd5, 16'hFFFF);
        send_level(5'd5, 16'hFFFF);
        send_level(5'd5, 16'hFFFF);
        end_phase();

        // Too many segments are capped at sixteen; the full ceiling leaves the
        // top segment of a full-scale level only partly filled. A decay factor of
        // zero leaves nothing held, and the threshold is one that nothing can exceed.
        write_config(16'hFFFF, 5'd31, 8'd0, 16'hFFFF);
        send_level(5'd5, 16'd0);
        send_level(5'd7, 16'hFFFF);
        send_level(5'd8, 16'd30000);
        send_level(5'd9, 16'd4095);
        end_phase();

        // Zero segments count as one; the held values of the hidden segments of
        // column 5 must survive until more segments are shown again.
        write_config(16'd1, 5'd0, 8'd200, 16'd16384);
        send_level(5'd5, 16'd0);
        send_level(5'd5, 16'd1);
        send_level(5'd5, 16'd2);
        send_level(5'd6, 16'hFFFF);
        end_phase();

        write_config(16'd40000, 5'd17, 8'd100, 16'd20000);
        send_level(5'd5, 16'd40000);
        send_level(5'd10, 16'd12345);
        end_phase();

        // Random phases. One runs with no idling on either side; in another the
        // receiver stalls for a long stretch while items keep being offered, so
        // the block backs up and holds off its input.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_config();
            steady <= (ph == 1);
            if (ph == 3) begin
                fork
                    random_items(ITEMS_PER_PHASE);
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                join
            end else begin
                random_items(ITEMS_PER_PHASE);
            end
            end_phase();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: gives up when neither channel has moved an item for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== bar_meter_segment_decay.f =====
rtl/bms_pkg.sv
rtl/bms_divider.sv
rtl/bms_held_store.sv
rtl/bar_meter_segment_decay.sv
tb/sv/segment_brightness_checker.sv
tb/sv/bar_meter_segment_decay_tb.sv
